// ===== rtl/bst_pkg.sv =====
// Shared types and constants for the bencode stream tokenizer.
`default_nettype none

package bst_pkg;

  // Parser phases.
  localparam logic [3:0] PH_START      = 4'd0;
  localparam logic [3:0] PH_DICT_KEY   = 4'd1;
  localparam logic [3:0] PH_DICT_VAL   = 4'd2;
  localparam logic [3:0] PH_LIST_ITEM  = 4'd3;
  localparam logic [3:0] PH_INT_FIRST  = 4'd4;
  localparam logic [3:0] PH_INT_DIGITS = 4'd5;
  localparam logic [3:0] PH_STR_LEN    = 4'd6;
  localparam logic [3:0] PH_STR_BODY   = 4'd7;
  localparam logic [3:0] PH_DONE       = 4'd8;
  localparam logic [3:0] PH_ERROR      = 4'd9;

  // Token events.
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_DICT_OPEN = 3'd1;
  localparam logic [2:0] EV_LIST_OPEN = 3'd2;
  localparam logic [2:0] EV_INT_DONE  = 3'd3;
  localparam logic [2:0] EV_STR_HDR   = 3'd4;
  localparam logic [2:0] EV_STR_BYTE  = 3'd5;
  localparam logic [2:0] EV_CLOSE     = 3'd6;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_BYTE = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_TOO_DEEP = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;

  // Syntax bytes.
  localparam logic [7:0] CH_DICT  = 8'h64;  // 'd'
  localparam logic [7:0] CH_LIST  = 8'h6C;  // 'l'
  localparam logic [7:0] CH_INT   = 8'h69;  // 'i'
  localparam logic [7:0] CH_END   = 8'h65;  // 'e'
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  localparam int unsigned VAL_W  = 63;
  localparam int unsigned DATA_W = 88;  // 81 payload bits padded to whole bytes
  localparam int unsigned USER_W = 4;

  // Container stack operation requested by the step logic.
  typedef struct packed {
    logic push;
    logic pop;
    logic push_dict;
  } stk_op_t;

  // One result item.
  typedef struct packed {
    logic [2:0]       event_res;
    logic [VAL_W-1:0] token_value;
    logic [7:0]       body_byte;
    logic             is_key;
    logic [5:0]       nest_level;
    logic [2:0]       error_code;
    logic             doc_done;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/bst_step.sv =====
// Per-byte parser step: next state and token event from one input byte.
`default_nettype none

module bst_step import bst_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 32,
  parameter int unsigned DW        = $clog2(MAX_DEPTH + 1)
) (
  input  wire logic [7:0]       byte_i,
  input  wire logic             eob_i,
  input  wire logic [3:0]       phase_i,
  input  wire logic [DW-1:0]    depth_i,
  input  wire logic             stk_top_i,
  input  wire logic             stk_below_i,
  input  wire logic [VAL_W-1:0] acc_i,
  input  wire logic             key_i,
  input  wire logic [2:0]       err_i,
  output logic [3:0]            phase_o,
  output logic [DW-1:0]         depth_o,
  output stk_op_t               stk_op_o,
  output logic [VAL_W-1:0]      acc_o,
  output logic                  key_o,
  output logic [2:0]            err_o,
  output res_t                  res_o
);

  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_DEPTH);

  logic             is_dig;
  logic [3:0]       dig;
  logic [VAL_W+3:0] mac;
  logic             mac_ovf;
  logic [3:0]       fin_ph;
  logic [3:0]       close_ph;
  logic [DW-1:0]    depth_dn;
  logic             deep;
  logic [2:0]       ev;
  logic [VAL_W-1:0] tval;
  logic [7:0]       body;
  logic             keyo;

  assign is_dig  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign dig     = byte_i[3:0];
  // acc * 10 + digit as two shifted copies plus the digit.
  assign mac     = (VAL_W+4)'({acc_i, 3'b000}) + (VAL_W+4)'({acc_i, 1'b0})
                 + (VAL_W+4)'(dig);
  assign mac_ovf = |mac[VAL_W+3:VAL_W];
  assign deep    = depth_i >= DEPTH_MAX;
  assign depth_dn = depth_i - DW'(1);

  // Where to go once the current item completes.
  always_comb begin
    if (depth_i == '0) begin
      fin_ph = PH_DONE;
    end else if (stk_top_i) begin
      fin_ph = key_i ? PH_DICT_VAL : PH_DICT_KEY;
    end else begin
      fin_ph = PH_LIST_ITEM;
    end
    if (depth_dn == '0) begin
      close_ph = PH_DONE;
    end else if (stk_below_i) begin
      close_ph = PH_DICT_KEY;
    end else begin
      close_ph = PH_LIST_ITEM;
    end
  end

  always_comb begin
    phase_o  = phase_i;
    depth_o  = depth_i;
    stk_op_o = '0;
    acc_o    = acc_i;
    key_o    = key_i;
    err_o    = err_i;
    ev       = EV_NONE;
    tval     = '0;
    body     = '0;
    keyo     = 1'b0;

    case (phase_i)
      PH_START: begin
        if (byte_i == CH_DICT && !deep) begin
          stk_op_o = '{push: 1'b1, pop: 1'b0, push_dict: 1'b1};
          depth_o  = depth_i + DW'(1);
          key_o    = 1'b0;
          phase_o  = PH_DICT_KEY;
          ev       = EV_DICT_OPEN;
        end else if (byte_i == CH_DICT) begin
          err_o   = ERR_TOO_DEEP;
          phase_o = PH_ERROR;
        end else begin
          err_o   = ERR_BAD_BYTE;
          phase_o = PH_ERROR;
        end
      end
      PH_DICT_KEY, PH_DICT_VAL, PH_LIST_ITEM: begin
        if (byte_i == CH_END && phase_i != PH_DICT_VAL) begin
          stk_op_o.pop = 1'b1;
          depth_o      = depth_dn;
          key_o        = 1'b0;
          phase_o      = close_ph;
          ev           = EV_CLOSE;
        end else if (is_dig) begin
          key_o   = (phase_i == PH_DICT_KEY);
          acc_o   = VAL_W'(dig);
          phase_o = PH_STR_LEN;
        end else if (phase_i == PH_DICT_KEY) begin
          err_o   = ERR_BAD_BYTE;
          phase_o = PH_ERROR;
        end else if (byte_i == CH_DICT || byte_i == CH_LIST) begin
          if (deep) begin
            err_o   = ERR_TOO_DEEP;
            phase_o = PH_ERROR;
          end else begin
            stk_op_o.push      = 1'b1;
            stk_op_o.push_dict = (byte_i == CH_DICT);
            depth_o            = depth_i + DW'(1);
            key_o              = 1'b0;
            phase_o            = (byte_i == CH_DICT) ? PH_DICT_KEY : PH_LIST_ITEM;
            ev                 = (byte_i == CH_DICT) ? EV_DICT_OPEN : EV_LIST_OPEN;
          end
        end else if (byte_i == CH_INT) begin
          key_o   = 1'b0;
          phase_o = PH_INT_FIRST;
        end else begin
          err_o   = ERR_BAD_BYTE;
          phase_o = PH_ERROR;
        end
      end
      PH_INT_FIRST: begin
        if (is_dig) begin
          acc_o   = VAL_W'(dig);
          phase_o = PH_INT_DIGITS;
        end else begin
          err_o   = ERR_BAD_BYTE;
          phase_o = PH_ERROR;
        end
      end
      PH_INT_DIGITS, PH_STR_LEN: begin
        if (is_dig) begin
          if (mac_ovf) begin
            err_o   = ERR_OVERFLOW;
            phase_o = PH_ERROR;
          end else begin
            acc_o = mac[VAL_W-1:0];
          end
        end else if (byte_i == CH_END && phase_i == PH_INT_DIGITS) begin
          ev      = EV_INT_DONE;
          tval    = acc_i;
          key_o   = 1'b0;
          phase_o = fin_ph;
        end else if (byte_i == CH_COLON && phase_i == PH_STR_LEN) begin
          ev   = EV_STR_HDR;
          tval = acc_i;
          keyo = key_i;
          if (acc_i == '0) begin
            key_o   = 1'b0;
            phase_o = fin_ph;
          end else begin
            // The length stays in the accumulator and counts the body down.
            phase_o = PH_STR_BODY;
          end
        end else begin
          err_o   = ERR_BAD_BYTE;
          phase_o = PH_ERROR;
        end
      end
      PH_STR_BODY: begin
        ev    = EV_STR_BYTE;
        body  = byte_i;
        keyo  = key_i;
        acc_o = acc_i - VAL_W'(1);
        if (acc_i == VAL_W'(1)) begin
          key_o   = 1'b0;
          phase_o = fin_ph;
        end
      end
      default: begin
      end
    endcase

    // A buffer that ends before the outer close is truncated.
    if (eob_i && phase_o != PH_DONE && err_o == ERR_NONE) begin
      err_o = ERR_TRUNC;
    end
  end

  assign res_o.event_res   = ev;
  assign res_o.token_value = tval;
  assign res_o.body_byte   = body;
  assign res_o.is_key      = keyo;
  assign res_o.nest_level  = 6'(depth_o);
  assign res_o.error_code  = err_o;
  assign res_o.doc_done    = (phase_o == PH_DONE) && (err_o == ERR_NONE);

endmodule

`default_nettype wire

// ===== rtl/bst_skid.sv =====
// Two-entry output stage: result register plus skid register.
`default_nettype none

module bst_skid #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  logic         out_v_r;
  logic         skid_v_r;
  logic [W-1:0] out_d_r;
  logic [W-1:0] skid_d_r;
  logic         in_fire;

  assign in_ready  = !skid_v_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_v_r) begin
      if (skid_v_r) begin
        out_d_r <= skid_d_r;
      end else if (in_fire) begin
        out_d_r <= in_data;
      end
    end else if (in_fire) begin
      skid_d_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bencode_stream_tokenizer_core.sv =====
// Top level of the bencode stream tokenizer: parser state, container stack, output stage.
`default_nettype none

// A result is registered in the result register, or in the skid register while
// the output stalls, which keeps the input ready. Throughput: one byte per cycle
// while the skid register is empty; the per-byte decision, including the
// accumulator's multiply-by-ten-and-add, is one pass of logic between registers.
// Reset: rst_n is synchronous and active low; it clears the parser state,
// the container stack and both output stage entries.
module bencode_stream_tokenizer_core import bst_pkg::*; #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input stream: one document byte per transfer.
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,   // [7:0] in_byte
  input  wire logic              in_tlast,   // end_of_buffer
  // Result stream: one token event per input byte.
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DATA_W-1:0]      out_tdata,  // [62:0] token_value, [70:63] body_byte,
                                             // [76:71] nest_level, [79:77] error_code,
                                             // [80] doc_done, [87:81] zero
  output logic [USER_W-1:0]      out_tuser   // [2:0] event_res, [3] is_key
);

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);

  // Parser state. The accumulator also serves as the string body counter.
  logic [3:0]       phase_r;
  logic [DW-1:0]    depth_r;
  logic [VAL_W-1:0] acc_r;
  logic             key_r;
  logic [2:0]       err_r;
  // Container stack as a shift line: bit 0 is the innermost container
  // (1 = dictionary, 0 = list). The extra bit keeps the entry below the top
  // addressable even at a depth limit of one.
  logic [MAX_DEPTH:0] stk_r;

  logic [3:0]       phase_nxt;
  logic [DW-1:0]    depth_nxt;
  logic [VAL_W-1:0] acc_nxt;
  logic             key_nxt;
  logic [2:0]       err_nxt;
  stk_op_t          stk_op;
  res_t             res;
  logic             in_fire;
  logic [USER_W+DATA_W-1:0] res_packed;
  logic [USER_W+DATA_W-1:0] out_packed;

  assign in_fire = in_tvalid && in_tready;

  bst_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .DW        (DW)
  ) u_step (
    .byte_i      (in_tdata),
    .eob_i       (in_tlast),
    .phase_i     (phase_r),
    .depth_i     (depth_r),
    .stk_top_i   (stk_r[0]),
    .stk_below_i (stk_r[1]),
    .acc_i       (acc_r),
    .key_i       (key_r),
    .err_i       (err_r),
    .phase_o     (phase_nxt),
    .depth_o     (depth_nxt),
    .stk_op_o    (stk_op),
    .acc_o       (acc_nxt),
    .key_o       (key_nxt),
    .err_o       (err_nxt),
    .res_o       (res)
  );

  // State advances on each accepted byte. The last byte of a buffer returns
  // everything to the reset state so the next document starts clean.
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_tlast)) begin
      phase_r <= PH_START;
      depth_r <= '0;
      acc_r   <= '0;
      key_r   <= 1'b0;
      err_r   <= ERR_NONE;
      stk_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      depth_r <= depth_nxt;
      acc_r   <= acc_nxt;
      key_r   <= key_nxt;
      err_r   <= err_nxt;
      if (stk_op.push) begin
        stk_r <= {stk_r[MAX_DEPTH-1:0], stk_op.push_dict};
      end else if (stk_op.pop) begin
        stk_r <= {1'b0, stk_r[MAX_DEPTH:1]};
      end
    end
  end

  // Pack the result: tuser in the top bits, then the padded tdata.
  assign res_packed = {res.is_key, res.event_res,
                       (DATA_W-81)'(0), res.doc_done, res.error_code,
                       res.nest_level, res.body_byte, res.token_value};

  bst_skid #(
    .W (USER_W + DATA_W)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (res_packed),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_packed)
  );

  assign out_tdata = out_packed[DATA_W-1:0];
  assign out_tuser = out_packed[USER_W+DATA_W-1:DATA_W];

endmodule

`default_nettype wire
